// ===== rtl/sqe_pkg.sv =====
`timescale 1ns / 1ps

package sqe_pkg;

  localparam int unsigned DepthDef     = 32;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned PaddrW   = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ItemW    = 32;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned StatusW  = 2;

  localparam logic RegQueueMode = 1'b0;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_SWAP  = 3'd3,
    ACT_PRINT = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// ===== rtl/sqe_ram.sv =====
`timescale 1ns / 1ps

module sqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sqe_slot.sv =====
`timescale 1ns / 1ps

module sqe_slot #(
  parameter int unsigned DEPTH = 32
) (
  input  logic [$clog2(DEPTH)-1:0] top_i,
  input  logic [$clog2(DEPTH)-1:0] offset_i,
  output logic [$clog2(DEPTH)-1:0] slot_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [PW:0] wrapped;

  assign wrapped = {1'b0, top_i} + (PW + 1)'(DEPTH) - {1'b0, offset_i};

  always_comb begin
    if (top_i >= offset_i) begin
      slot_o = top_i - offset_i;
    end else begin
      slot_o = wrapped[PW-1:0];
    end
  end

endmodule

// ===== rtl/stack_queue_engine_top.sv =====
`timescale 1ns / 1ps

// Bounded store of signed entries that works as a stack or, with queue_mode set, as a
// queue. An item is taken when start is high and busy is low; busy then stays high until
// the item's last result has been produced. Results appear on the result ports for one
// cycle each, marked by result_valid_o, and the receiver cannot stall them. The entries
// sit in a RAM with a registered read, and every access runs through it one at a
// time: push, pop and unused actions finish in S_EXEC, peek adds S_PEEK, swap adds
// S_SW_A, S_SW_B and S_SW_C, and print streams all entries, one entry per cycle.
module stack_queue_engine_top #(
  parameter int unsigned DEPTH      = sqe_pkg::DepthDef,
  parameter int unsigned VALUE_BITS = sqe_pkg::ValueBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sqe_pkg::PaddrW-1:0]  paddr,
  input  logic [sqe_pkg::DataW-1:0]   pwdata,
  output logic [sqe_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [sqe_pkg::ActionW-1:0] action_i,
  input  logic signed [sqe_pkg::ItemW-1:0] push_value_i,
  output logic                        result_valid_o,
  output logic signed [sqe_pkg::ItemW-1:0] value_o,
  output logic                        has_value_o,
  output logic [sqe_pkg::StatusW-1:0] status_o,
  output logic                        last_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PEEK,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_PRINT
  } state_e;

  state_e                         state_q;
  logic                           queue_mode_q;
  logic [PW-1:0]                  top_q;
  logic [CW-1:0]                  count_q;
  logic [PW-1:0]                  cursor_q;
  logic [sqe_pkg::ActionW-1:0]    action_q;
  logic signed [sqe_pkg::ItemW-1:0] push_value_q;
  logic [VALUE_BITS-1:0]          tmp_q;

  logic                           res_valid_q;
  logic signed [sqe_pkg::ItemW-1:0] res_value_q;
  logic                           res_has_q;
  logic [sqe_pkg::StatusW-1:0]    res_status_q;
  logic                           res_last_q;

  logic                           ram_we;
  logic [PW-1:0]                  ram_waddr;
  logic [VALUE_BITS-1:0]          ram_wdata;
  logic                           ram_re;
  logic [PW-1:0]                  ram_raddr;
  logic [VALUE_BITS-1:0]          ram_rdata;

  logic [PW-1:0]                  slot_offset;
  logic [PW-1:0]                  slot;
  logic [PW-1:0]                  top_inc;
  logic [PW-1:0]                  cursor_inc;
  logic                           is_full;
  logic                           is_empty;
  logic                           is_short;
  logic                           print_last;
  logic                           accept;
  logic                           cfg_write;
  logic signed [sqe_pkg::ItemW-1:0] read_value;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == sqe_pkg::RegQueueMode)
                     ? {{(sqe_pkg::DataW-1){1'b0}}, queue_mode_q} : '0;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign is_short   = (count_q < CW'(2));
  assign top_inc    = (top_q == PW'(DEPTH - 1)) ? '0 : top_q + PW'(1);
  assign cursor_inc = cursor_q + PW'(1);
  assign print_last = (({1'b0, cursor_q} + (PW + 1)'(1)) == (PW + 1)'(count_q));
  assign read_value = sqe_pkg::ItemW'($signed(ram_rdata));

  always_comb begin
    case (state_q)
      S_EXEC: begin
        slot_offset = (action_q == sqe_pkg::ACT_POP) ? PW'(1) : count_q[PW-1:0];
      end
      S_PRINT: begin
        slot_offset = cursor_inc;
      end
      default: begin
        slot_offset = PW'(1);
      end
    endcase
  end

  sqe_slot #(
    .DEPTH(DEPTH)
  ) u_slot (
    .top_i   (top_q),
    .offset_i(slot_offset),
    .slot_o  (slot)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = top_q;
    ram_wdata = VALUE_BITS'(push_value_q);
    ram_re    = 1'b0;
    ram_raddr = top_q;
    case (state_q)
      S_EXEC: begin
        case (action_q)
          sqe_pkg::ACT_PUSH: begin
            ram_we    = !is_full;
            ram_waddr = queue_mode_q ? slot : top_inc;
          end
          sqe_pkg::ACT_PEEK, sqe_pkg::ACT_PRINT: begin
            ram_re = !is_empty;
          end
          sqe_pkg::ACT_SWAP: begin
            ram_re = !is_short;
          end
          default: begin
            ram_re = 1'b0;
          end
        endcase
      end
      S_SW_A: begin
        ram_re    = 1'b1;
        ram_raddr = slot;
      end
      S_SW_B: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SW_C: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = tmp_q;
      end
      S_PRINT: begin
        ram_re    = !print_last;
        ram_raddr = slot;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sqe_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q     <= action_i;
      push_value_q <= push_value_i;
    end
    if (state_q == S_SW_A) begin
      tmp_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      queue_mode_q <= 1'b0;
      top_q        <= '0;
      count_q      <= '0;
      cursor_q     <= '0;
      res_valid_q  <= 1'b0;
      res_value_q  <= '0;
      res_has_q    <= 1'b0;
      res_status_q <= sqe_pkg::ST_OK;
      res_last_q   <= 1'b0;
    end else begin
      res_valid_q  <= 1'b0;
      res_value_q  <= '0;
      res_has_q    <= 1'b0;
      res_status_q <= sqe_pkg::ST_OK;
      res_last_q   <= 1'b1;
      if (cfg_write && (paddr[2] == sqe_pkg::RegQueueMode)) begin
        queue_mode_q <= pwdata[0];
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          case (action_q)
            sqe_pkg::ACT_PUSH: begin
              res_valid_q <= 1'b1;
              if (is_full) begin
                res_status_q <= sqe_pkg::ST_FULL;
              end else begin
                count_q <= count_q + CW'(1);
                if (!queue_mode_q) begin
                  top_q <= top_inc;
                end
              end
            end
            sqe_pkg::ACT_POP: begin
              res_valid_q <= 1'b1;
              if (is_empty) begin
                res_status_q <= sqe_pkg::ST_EMPTY;
              end else begin
                top_q   <= slot;
                count_q <= count_q - CW'(1);
              end
            end
            sqe_pkg::ACT_PEEK: begin
              if (is_empty) begin
                res_valid_q  <= 1'b1;
                res_status_q <= sqe_pkg::ST_EMPTY;
              end else begin
                state_q <= S_PEEK;
              end
            end
            sqe_pkg::ACT_SWAP: begin
              if (is_short) begin
                res_valid_q  <= 1'b1;
                res_status_q <= sqe_pkg::ST_SHORT;
              end else begin
                state_q <= S_SW_A;
              end
            end
            sqe_pkg::ACT_PRINT: begin
              if (is_empty) begin
                res_valid_q <= 1'b1;
              end else begin
                cursor_q <= '0;
                state_q  <= S_PRINT;
              end
            end
            default: begin
              res_valid_q <= 1'b1;
            end
          endcase
        end
        S_PEEK: begin
          state_q     <= S_IDLE;
          res_valid_q <= 1'b1;
          res_value_q <= read_value;
          res_has_q   <= 1'b1;
        end
        S_SW_A: begin
          state_q <= S_SW_B;
        end
        S_SW_B: begin
          state_q <= S_SW_C;
        end
        S_SW_C: begin
          state_q     <= S_IDLE;
          res_valid_q <= 1'b1;
        end
        S_PRINT: begin
          res_valid_q <= 1'b1;
          res_value_q <= read_value;
          res_has_q   <= 1'b1;
          res_last_q  <= print_last;
          if (print_last) begin
            state_q  <= S_IDLE;
            cursor_q <= '0;
          end else begin
            cursor_q <= cursor_inc;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign value_o        = res_value_q;
  assign has_value_o    = res_has_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule

// ===== rtl/sqe_checker.sv =====
`timescale 1ns / 1ps

module sqe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic                        has_value_o,
  input logic [sqe_pkg::StatusW-1:0] status_o,
  input logic                        last_o
);

  a_value_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && has_value_o |-> status_o == sqe_pkg::ST_OK)
    else $error("An entry was returned together with an error status.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("The block did not go busy after taking an item.");

  a_last_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("The block stayed busy after the last result of an item.");

  a_more_results_keep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy && has_value_o)
    else $error("A result that is not the last one came while the block was idle.");

  a_busy_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("The block went busy without an item being offered.");

endmodule

bind stack_queue_engine_top sqe_checker u_sqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .has_value_o   (has_value_o),
  .status_o      (status_o),
  .last_o        (last_o)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth = sqe_pkg::DepthDef;
  localparam int unsigned PtrW = $clog2(sqe_pkg::DepthDef);
  localparam logic [sqe_pkg::ActionW-1:0] ActUnusedFirst = 3'd5;
  localparam logic [sqe_pkg::ActionW-1:0] ActUnusedLast = 3'd7;
  localparam logic [sqe_pkg::PaddrW-1:0] AddrQueueMode =
    sqe_pkg::PaddrW'(4 * sqe_pkg::RegQueueMode);
  localparam logic [sqe_pkg::PaddrW-1:0] AddrUnmapped =
    sqe_pkg::PaddrW'(4 * (sqe_pkg::RegQueueMode + 1));
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic signed [sqe_pkg::ItemW-1:0] value;
    logic                             has_value;
    logic [sqe_pkg::StatusW-1:0]      status;
    logic                             last;
  } result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [sqe_pkg::PaddrW-1:0]       paddr;
  logic [sqe_pkg::DataW-1:0]        pwdata;
  logic [sqe_pkg::DataW-1:0]        prdata;
  logic                             pready;
  logic                             start;
  logic                             busy;
  logic [sqe_pkg::ActionW-1:0]      action_i;
  logic signed [sqe_pkg::ItemW-1:0] push_value_i;
  logic                             result_valid_o;
  logic signed [sqe_pkg::ItemW-1:0] value_o;
  logic                             has_value_o;
  logic [sqe_pkg::StatusW-1:0]      status_o;
  logic                             last_o;

  stack_queue_engine_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .value_o        (value_o),
    .has_value_o    (has_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  result_t                          pending_results[$];
  logic signed [sqe_pkg::ItemW-1:0] shadow_store[Depth];
  logic [PtrW-1:0]                  shadow_top = '0;
  int unsigned                      shadow_count = 0;
  logic                             shadow_queue_mode = 1'b0;

  int unsigned sender_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned short_hits = 0;
  int unsigned deepest = 0;
  int unsigned stall_cycles = 0;

  function automatic logic [PtrW-1:0] slot_below_top(int unsigned k);
    return shadow_top - PtrW'(k);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void expect_result(logic signed [sqe_pkg::ItemW-1:0] value, logic has,
                                        sqe_pkg::status_e st, logic last);
    result_t r;
    r.value = value;
    r.has_value = has;
    r.status = st;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_item(logic [sqe_pkg::ActionW-1:0] act,
                                       logic signed [sqe_pkg::ItemW-1:0] v);
    logic signed [sqe_pkg::ItemW-1:0] held;
    case (act)
      sqe_pkg::ACT_PUSH: begin
        if (shadow_count >= Depth) begin
          full_hits++;
          expect_result('0, 1'b0, sqe_pkg::ST_FULL, 1'b1);
        end else begin
          if (shadow_queue_mode) begin
            shadow_store[slot_below_top(shadow_count)] = v;
          end else begin
            shadow_top++;
            shadow_store[shadow_top] = v;
          end
          shadow_count++;
          if (shadow_count > deepest) deepest = shadow_count;
          expect_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::ACT_POP: begin
        if (shadow_count == 0) begin
          empty_hits++;
          expect_result('0, 1'b0, sqe_pkg::ST_EMPTY, 1'b1);
        end else begin
          shadow_top = slot_below_top(1);
          shadow_count--;
          expect_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::ACT_PEEK: begin
        if (shadow_count == 0) begin
          empty_hits++;
          expect_result('0, 1'b0, sqe_pkg::ST_EMPTY, 1'b1);
        end else begin
          expect_result(shadow_store[shadow_top], 1'b1, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::ACT_SWAP: begin
        if (shadow_count < 2) begin
          short_hits++;
          expect_result('0, 1'b0, sqe_pkg::ST_SHORT, 1'b1);
        end else begin
          held = shadow_store[shadow_top];
          shadow_store[shadow_top] = shadow_store[slot_below_top(1)];
          shadow_store[slot_below_top(1)] = held;
          expect_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::ACT_PRINT: begin
        if (shadow_count == 0) begin
          expect_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end else begin
          for (int unsigned k = 0; k < shadow_count; k++) begin
            expect_result(shadow_store[slot_below_top(k)], 1'b1, sqe_pkg::ST_OK,
                          k + 1 == shadow_count);
          end
        end
      end
      default: begin
        expect_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
      end
    endcase
  endfunction

  function automatic logic signed [sqe_pkg::ItemW-1:0] pick_value();
    case ($urandom_range(9))
      0: return {1'b1, {(sqe_pkg::ItemW-1){1'b0}}};
      1: return {1'b0, {(sqe_pkg::ItemW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sqe_pkg::ActionW-1:0] pick_action(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return sqe_pkg::ACT_PUSH;
    r = $urandom_range(99);
    if (r < 45) return sqe_pkg::ACT_POP;
    if (r < 65) return sqe_pkg::ACT_PEEK;
    if (r < 80) return sqe_pkg::ACT_SWAP;
    if (r < 92) return sqe_pkg::ACT_PRINT;
    return sqe_pkg::ActionW'($urandom_range(ActUnusedFirst, ActUnusedLast));
  endfunction

  task automatic send_item(input logic [sqe_pkg::ActionW-1:0] act,
                           input logic signed [sqe_pkg::ItemW-1:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    action_i <= act;
    push_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(act, v);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [sqe_pkg::PaddrW-1:0] addr,
                            input logic [sqe_pkg::DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (wr && addr == AddrQueueMode) begin
      shadow_queue_mode = data[0];
    end else if (!wr && addr == AddrQueueMode &&
                 prdata !== sqe_pkg::DataW'(shadow_queue_mode)) begin
      flag_mismatch($sformatf("queue_mode readback: expected %0h, got %0h",
                              sqe_pkg::DataW'(shadow_queue_mode), prdata));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic mode);
    wait_idle();
    apb_access(1'b1, AddrQueueMode,
               {(sqe_pkg::DataW-1)'($urandom_range(32'h7fff_ffff)), mode});
    apb_access(1'b0, AddrQueueMode, '0);
  endtask

  task automatic test_directed();
    set_mode(1'b0);
    send_item(sqe_pkg::ACT_POP, pick_value());
    send_item(sqe_pkg::ACT_PEEK, pick_value());
    send_item(sqe_pkg::ACT_SWAP, pick_value());
    send_item(sqe_pkg::ACT_PRINT, pick_value());
    send_item(ActUnusedFirst, pick_value());
    send_item(sqe_pkg::ACT_PUSH, {1'b1, {(sqe_pkg::ItemW-1){1'b0}}});
    send_item(sqe_pkg::ACT_SWAP, '0);
    send_item(sqe_pkg::ACT_PEEK, '1);
    send_item(sqe_pkg::ACT_PUSH, {1'b0, {(sqe_pkg::ItemW-1){1'b1}}});
    send_item(sqe_pkg::ACT_PUSH, '0);
    send_item(sqe_pkg::ACT_PUSH, '1);
    send_item(sqe_pkg::ACT_SWAP, pick_value());
    send_item(sqe_pkg::ACT_PEEK, pick_value());
    send_item(sqe_pkg::ACT_PRINT, pick_value());
    send_item(sqe_pkg::ActionW'(6), pick_value());
    send_item(ActUnusedLast, '1);
    send_item(sqe_pkg::ACT_POP, pick_value());
    send_item(sqe_pkg::ACT_PRINT, '0);
    repeat (4) send_item(sqe_pkg::ACT_POP, pick_value());
  endtask

  task automatic test_fill_and_drain();
    set_mode(1'b1);
    apb_access(1'b1, AddrUnmapped, $urandom);
    while (shadow_count < Depth) send_item(sqe_pkg::ACT_PUSH, pick_value());
    send_item(sqe_pkg::ACT_PUSH, pick_value());
    send_item(sqe_pkg::ACT_PEEK, pick_value());
    send_item(sqe_pkg::ACT_SWAP, pick_value());
    send_item(sqe_pkg::ACT_PRINT, pick_value());
    while (shadow_count > 0) send_item(sqe_pkg::ACT_POP, pick_value());
    send_item(sqe_pkg::ACT_POP, pick_value());
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input logic mode,
                                   input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    bit filling;
    set_mode(mode);
    sender_idle_pct = idle_pct;
    sent = 0;
    filling = 1'b1;
    while (sent < count) begin
      burst = $urandom_range(5, 30);
      repeat (burst) begin
        if (sent < count) begin
          send_item(pick_action(filling ? 75 : 25), pick_value());
          sent++;
        end
      end
      filling = !filling;
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      got.value = value_o;
      got.has_value = has_value_o;
      got.status = status_o;
      got.last = last_o;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no item pending: value %0d status %0d",
                                got.value, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.has_value !== want.has_value ||
            got.status !== want.status || got.last !== want.last) begin
          flag_mismatch($sformatf({"result mismatch: expected value %0d has %0b status %0d ",
                                   "last %0b, got value %0d has %0b status %0d last %0b"},
                                  want.value, want.has_value, want.status, want.last,
                                  got.value, got.has_value, got.status, got.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Timeout with %0d results still pending.", pending_results.size());
      $display("stack_queue_engine_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    action_i = sqe_pkg::ACT_PUSH;
    push_value_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random_phase(0, 1'b0, 60);
    test_random_phase(69, 1'b1, 60);
    test_random_phase(30, 1'($urandom_range(1)), 60);
    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Checked %0d results from %0d items in stack and queue mode, deepest %0d entries.",
             results_seen, items_sent, deepest);
    $display("Store full %0d times, empty %0d times, short swap %0d times, %0d mismatches.",
             full_hits, empty_hits, short_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("stack_queue_engine_top regression: pass");
    end else begin
      $display("stack_queue_engine_top regression: fail");
    end
    $finish;
  end

endmodule
